// ----- rtl/core/clcd_pkg.sv -----
// Shared types and constants for the character LCD command sequencer.
// No dependencies.
package clcd_pkg;

	localparam int MAX_BLANK_DEF = 16;

	typedef enum logic [3:0] {
		OP_INIT   = 4'd0,
		OP_INS    = 4'd1,
		OP_CHAR   = 4'd2,
		OP_CURSOR = 4'd3,
		OP_CLEAR  = 4'd4,
		OP_DEC    = 4'd5,
		OP_FOUR   = 4'd6,
		OP_BIN    = 4'd7,
		OP_BLANK  = 4'd8,
		OP_GLYPH  = 4'd9
	} op_t;

	localparam logic [1:0] REG_BUS_MODE = 2'd0;
	localparam logic [1:0] REG_DISP_CTL = 2'd1;
	localparam logic [1:0] REG_EN_HIGH  = 2'd2;
	localparam logic [1:0] REG_EN_LOW   = 2'd3;

	localparam logic [7:0] INS_FUNC8   = 8'h38;
	localparam logic [7:0] INS_FUNC4   = 8'h28;
	localparam logic [7:0] INS_HOME    = 8'h02;
	localparam logic [7:0] INS_CLEAR   = 8'h01;
	localparam logic [7:0] INS_ENTRY   = 8'h06;
	localparam logic [7:0] INS_DDRAM   = 8'h80;
	localparam logic [7:0] INS_LINE1   = 8'hC0;
	localparam logic [7:0] INS_CGRAM   = 8'h40;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;

	typedef struct packed {
		logic [3:0]  op;
		logic [7:0]  byte_value;
		logic signed [31:0] number;
		logic        line;
		logic [5:0]  column;
		logic [4:0]  blank_count;
		logic [63:0] glyph_rows;
	} cmd_t;

	typedef struct packed {
		logic       reg_select;
		logic [7:0] bus_value;
		logic       last;
	} strobe_t;

	// controller to datapath
	typedef struct packed {
		logic       load;      // capture command magnitude
		logic       div_step;  // divide the magnitude by ten
		logic       emit;      // present a byte
		logic       rs;
		logic [7:0] byte_v;
		logic       lo_nib;    // send low nibble of byte
		logic       last;
	} dp_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic       mag_zero;
		logic [3:0] digit;
	} dp_sts_t;

endpackage

// ----- rtl/core/clcd_datapath.sv -----
// Datapath: holds the magnitude, peels one decimal digit a cycle by reciprocal
// multiply, and drives the strobe output register. Uses clcd_pkg.
module clcd_datapath import clcd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     bus_mode,
	input  dp_ctl_t  ctl,
	input  logic [31:0] mag_in,
	output dp_sts_t  sts,
	output logic     strobe,
	output strobe_t  result
);
	logic [31:0] quo_q;
	logic [63:0] prod;
	logic [28:0] q10;
	logic [3:0]  rem;

	// floor(x / 10) = (x * 0xCCCCCCCD) >> 35 for every 32-bit x
	assign prod = 64'(quo_q) * 64'(32'hCCCC_CCCD);
	assign q10  = prod[63:35];
	assign rem  = 4'(quo_q - {q10, 3'd0} - {2'd0, q10, 1'b0});

	always_ff @(posedge clk) begin
		if (ctl.load)          quo_q <= mag_in;
		else if (ctl.div_step) quo_q <= {3'd0, q10};
	end

	assign sts.mag_zero = (quo_q == 32'd0);
	assign sts.digit    = rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else         strobe <= ctl.emit;
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result.reg_select <= ctl.rs;
			result.last       <= ctl.last;
			if (!bus_mode)       result.bus_value <= ctl.byte_v;
			else if (ctl.lo_nib) result.bus_value <= {4'd0, ctl.byte_v[3:0]};
			else                 result.bus_value <= {4'd0, ctl.byte_v[7:4]};
		end
	end
endmodule

// ----- rtl/core/clcd_ctrl.sv -----
// Controller: sequences bytes of a command, nibble halves, and enable timing.
// Uses clcd_pkg; commands the datapath through dp_ctl_t.
module clcd_ctrl import clcd_pkg::*; #(
	parameter int MAX_BLANK = MAX_BLANK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cmd_t        cmd,
	input  logic        bus_mode,
	input  logic [7:0]  display_control,
	input  logic [15:0] enable_high_ticks,
	input  logic [15:0] enable_low_ticks,
	input  dp_sts_t     sts,
	output logic        busy,
	output dp_ctl_t     ctl
);
	localparam int CW = $clog2(MAX_BLANK + 1) > 5 ? $clog2(MAX_BLANK + 1) : 5;

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_SEND, S_HOLD_HI, S_HOLD_LO} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [5:0]  idx_q;     // byte index within command
	logic [5:0]  nbytes_q;  // total bytes
	logic        half_q;
	logic [16:0] tick_q;
	logic [3:0]  dig_q [10];
	logic [3:0]  ndig_q;
	logic        neg_q;
	logic [CW-1:0] cnt_sat;

	logic [7:0]  cur_byte;
	logic        cur_rs;
	logic [7:0]  cursor_b;
	logic [3:0]  dsel;

	assign cursor_b = cmd_q.line ? 8'(INS_LINE1 + {2'd0, cmd_q.column})
	                             : (INS_DDRAM | {2'd0, cmd_q.column});
	assign cnt_sat = (CW'(cmd.blank_count) > CW'(MAX_BLANK)) ?
		CW'(MAX_BLANK) : CW'(cmd.blank_count);
	assign dsel = 4'(ndig_q - 4'd1 - 4'(idx_q - {5'd0, neg_q}));

	always_comb begin
		cur_rs   = 1'b1;
		cur_byte = '0;
		case (op_t'(cmd_q.op))
			OP_INIT: begin
				cur_rs = 1'b0;
				if (bus_mode) begin
					case (idx_q)
						6'd0: cur_byte = INS_HOME;
						6'd1: cur_byte = INS_FUNC4;
						6'd2: cur_byte = display_control;
						6'd3: cur_byte = INS_CLEAR;
						default: cur_byte = INS_ENTRY;
					endcase
				end else begin
					case (idx_q)
						6'd0: cur_byte = INS_FUNC8;
						6'd1: cur_byte = display_control;
						6'd2: cur_byte = INS_CLEAR;
						default: cur_byte = INS_ENTRY;
					endcase
				end
			end
			OP_INS:    begin cur_rs = 1'b0; cur_byte = cmd_q.byte_value; end
			OP_CHAR:   cur_byte = cmd_q.byte_value;
			OP_CURSOR: begin cur_rs = 1'b0; cur_byte = cursor_b; end
			OP_CLEAR:  begin cur_rs = 1'b0; cur_byte = INS_CLEAR; end
			OP_DEC, OP_FOUR: begin
				if (neg_q && idx_q == 6'd0) cur_byte = CHAR_MINUS;
				else cur_byte = CHAR_ZERO | {4'd0, dig_q[dsel]};
			end
			OP_BIN: cur_byte = CHAR_ZERO | {7'd0, cmd_q.byte_value[3'(3'd7 - idx_q[2:0])]};
			OP_BLANK: begin
				if (idx_q == 6'd0) begin cur_rs = 1'b0; cur_byte = cursor_b; end
				else cur_byte = CHAR_SPACE;
			end
			OP_GLYPH: begin
				if (idx_q == 6'd0) begin
					cur_rs = 1'b0;
					cur_byte = INS_CGRAM | {2'd0, cmd_q.byte_value[2:0], 3'd0};
				end else if (idx_q == 6'd9) begin
					cur_rs = 1'b0;
					cur_byte = INS_DDRAM;
				end else begin
					cur_byte = cmd_q.glyph_rows[8*3'(idx_q[2:0] - 3'd1) +: 8];
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl        = '0;
		ctl.load   = start && !busy;
		ctl.rs     = cur_rs;
		ctl.byte_v = cur_byte;
		ctl.lo_nib = half_q;
		ctl.last   = (idx_q == 6'(nbytes_q - 6'd1)) && (half_q || !bus_mode);
		if (state_q == S_SEND) ctl.emit = 1'b1;
		// four-digit runs exactly four steps; decimal runs until the magnitude is zero
		if (state_q == S_DIV && ((op_t'(cmd_q.op) == OP_FOUR) ? (ndig_q != 4'd4)
		                                                       : !sts.mag_zero))
			ctl.div_step = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			idx_q    <= '0;
			nbytes_q <= '0;
			half_q   <= 1'b0;
			tick_q   <= '0;
			ndig_q   <= '0;
			neg_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (start) begin
					idx_q  <= '0;
					half_q <= 1'b0;
					ndig_q <= '0;
					neg_q  <= 1'b0;
					state_q <= S_SEND;
					case (op_t'(cmd.op))
						OP_INIT:   nbytes_q <= bus_mode ? 6'd5 : 6'd4;
						OP_INS, OP_CHAR, OP_CURSOR, OP_CLEAR: nbytes_q <= 6'd1;
						OP_DEC: begin
							neg_q <= cmd.number[31];
							state_q <= S_DIV;
						end
						OP_FOUR: state_q <= S_DIV;
						OP_BIN:   nbytes_q <= 6'd8;
						OP_BLANK: nbytes_q <= 6'(cnt_sat) + 6'd1;
						OP_GLYPH: nbytes_q <= 6'd10;
						default:  state_q <= S_IDLE;
					endcase
				end
				S_DIV: begin
					if (ctl.div_step) ndig_q <= ndig_q + 4'd1;
					else begin
						state_q <= S_SEND;
						// zero prints a single '0'
						if (ndig_q == 4'd0) begin
							ndig_q   <= 4'd1;
							nbytes_q <= 6'd1;
						end else begin
							nbytes_q <= 6'(ndig_q) + {5'd0, neg_q};
						end
					end
				end
				S_SEND: begin
					state_q <= S_HOLD_HI;
					tick_q  <= {1'b0, enable_high_ticks};
				end
				S_HOLD_HI: begin
					if (tick_q <= 17'd1) begin
						state_q <= S_HOLD_LO;
						tick_q  <= {1'b0, enable_low_ticks};
					end else tick_q <= tick_q - 17'd1;
				end
				S_HOLD_LO: begin
					if (tick_q <= 17'd1) begin
						if (bus_mode && !half_q) begin
							half_q  <= 1'b1;
							state_q <= S_SEND;
						end else begin
							half_q <= 1'b0;
							if (idx_q == 6'(nbytes_q - 6'd1)) state_q <= S_IDLE;
							else begin
								idx_q   <= idx_q + 6'd1;
								state_q <= S_SEND;
							end
						end
					end else tick_q <= tick_q - 17'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// digits stack up ones first
	always_ff @(posedge clk) begin
		if (ctl.div_step) dig_q[ndig_q] <= sts.digit;
		else if (state_q == S_DIV && ndig_q == 4'd0) dig_q[0] <= 4'd0;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) cmd_q <= cmd;
	end
endmodule

// ----- rtl/core/char_lcd_command_sequencer.sv -----
// Top level of the character LCD command sequencer.
// Joins clcd_ctrl and clcd_datapath; uses clcd_pkg.
//
// Usage: drive cmd and raise start; the command is taken at a clock edge
// where start is high and busy is low. Each resulting enable beat appears
// on result for one cycle with strobe high; last marks the command's final
// beat. The receiver cannot stall: every beat is one cycle wide.
// Timing: the hold counter paces each beat from enable_high_ticks for
// the high time and enable_low_ticks for the low time (a hold of zero
// counts as one). Decimal and four-digit commands first peel one digit
// per cycle with a reciprocal multiply. The first beat reaches result
// via S_DIV if any, the S_SEND state and the strobe register. Busy stays
// high until the last beat's low time has run out; a new command can be
// taken at the next edge. Configuration is written on cfg_valid/cfg_ready,
// always ready; writes beyond the register list are dropped.
// Reset: registers return to 4-bit bus, control 0x0C, 1000-tick holds.
module char_lcd_command_sequencer import clcd_pkg::*; #(
	parameter int MAX_BLANK = MAX_BLANK_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        strobe,
	output strobe_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic        bus_mode_q;
	logic [7:0]  disp_ctl_q;
	logic [15:0] en_high_q, en_low_q;
	dp_ctl_t     ctl;
	dp_sts_t     sts;
	logic [31:0] mag;

	assign cfg_ready = 1'b1;
	assign mag = cmd.number[31] ? 32'(32'd0 - cmd.number) : cmd.number;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_mode_q <= 1'b1;
			disp_ctl_q <= 8'h0C;
			en_high_q  <= 16'd1000;
			en_low_q   <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BUS_MODE: bus_mode_q <= cfg_data[0];
				REG_DISP_CTL: disp_ctl_q <= cfg_data[7:0];
				REG_EN_HIGH:  en_high_q  <= cfg_data;
				REG_EN_LOW:   en_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	clcd_ctrl #(.MAX_BLANK(MAX_BLANK)) u_ctrl (
		.clk, .arst_n, .start, .cmd,
		.bus_mode(bus_mode_q), .display_control(disp_ctl_q),
		.enable_high_ticks(en_high_q), .enable_low_ticks(en_low_q),
		.sts, .busy, .ctl
	);

	clcd_datapath u_dp (
		.clk, .arst_n, .bus_mode(bus_mode_q), .ctl,
		.mag_in(op_t'(cmd.op) == OP_FOUR ? {16'd0, cmd.number[15:0]} : mag),
		.sts, .strobe, .result
	);

`ifndef SYNTHESIS
	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("strobe while idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> busy) else $error("dropped busy mid command");
`endif
endmodule

// ----- tb/char_lcd_command_sequencer_test.sv -----
// Self-checking testbench for the character LCD command sequencer.
// Depends on clcd_pkg and char_lcd_command_sequencer; predicts every enable beat.
module char_lcd_command_sequencer_test;
	import clcd_pkg::*;

	class strobe_scoreboard;
		bit       nibble_bus = 1'b1;
		bit [7:0] disp_ctl = 8'h0C;
		strobe_t  pending_beats[$];
		int       errors;
		int       beats_seen;
		int       cmds_seen;

		function void push_byte(bit rs, bit [7:0] b);
			strobe_t s;
			s.reg_select = rs;
			s.last = 1'b0;
			if (nibble_bus) begin
				s.bus_value = {4'h0, b[7:4]};
				pending_beats.push_back(s);
				s.bus_value = {4'h0, b[3:0]};
				pending_beats.push_back(s);
			end else begin
				s.bus_value = b;
				pending_beats.push_back(s);
			end
		endfunction

		function void push_cursor(bit ln, bit [5:0] col);
			if (!ln) push_byte(1'b0, INS_DDRAM | {2'b00, col});
			else push_byte(1'b0, INS_LINE1 + {2'b00, col});
		endfunction

		function void push_decimal(bit [31:0] raw);
			bit [31:0] mag;
			bit [7:0]  digits[$];
			mag = raw;
			if (raw == 0) begin
				push_byte(1'b1, CHAR_ZERO);
				return;
			end
			if (raw[31]) begin
				mag = -raw;
				push_byte(1'b1, CHAR_MINUS);
			end
			while (mag != 0) begin
				digits.push_front(CHAR_ZERO + 8'(mag % 10));
				mag = mag / 10;
			end
			foreach (digits[i]) push_byte(1'b1, digits[i]);
		endfunction

		// work out the beats of one accepted command
		function void note_command(cmd_t c);
			int       first;
			int       cnt;
			bit [15:0] v;
			first = pending_beats.size();
			cmds_seen++;
			case (c.op)
				OP_INIT: begin
					if (nibble_bus) begin
						push_byte(1'b0, INS_HOME);
						push_byte(1'b0, INS_FUNC4);
					end else begin
						push_byte(1'b0, INS_FUNC8);
					end
					push_byte(1'b0, disp_ctl);
					push_byte(1'b0, INS_CLEAR);
					push_byte(1'b0, INS_ENTRY);
				end
				OP_INS: push_byte(1'b0, c.byte_value);
				OP_CHAR: push_byte(1'b1, c.byte_value);
				OP_CURSOR: push_cursor(c.line, c.column);
				OP_CLEAR: push_byte(1'b0, INS_CLEAR);
				OP_DEC: push_decimal(c.number);
				OP_FOUR: begin
					v = c.number[15:0] % 10000;
					push_byte(1'b1, CHAR_ZERO + 8'(v / 1000));
					push_byte(1'b1, CHAR_ZERO + 8'((v % 1000) / 100));
					push_byte(1'b1, CHAR_ZERO + 8'((v % 100) / 10));
					push_byte(1'b1, CHAR_ZERO + 8'(v % 10));
				end
				OP_BIN: for (int i = 7; i >= 0; i--)
					push_byte(1'b1, CHAR_ZERO + 8'(c.byte_value[i]));
				OP_BLANK: begin
					cnt = (c.blank_count > MAX_BLANK_DEF) ? MAX_BLANK_DEF : c.blank_count;
					push_cursor(c.line, c.column);
					for (int i = 0; i < cnt; i++) push_byte(1'b1, CHAR_SPACE);
				end
				OP_GLYPH: begin
					push_byte(1'b0, INS_CGRAM + {2'b00, c.byte_value[2:0], 3'b000});
					for (int i = 0; i < 8; i++) push_byte(1'b1, c.glyph_rows[8*i +: 8]);
					push_byte(1'b0, INS_DDRAM);
				end
				default: ;
			endcase
			if (pending_beats.size() > first)
				pending_beats[pending_beats.size()-1].last = 1'b1;
		endfunction

		function void check_beat(strobe_t got);
			strobe_t exp;
			beats_seen++;
			if (pending_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat rs=%0b value=%02h last=%0b",
					$realtime, got.reg_select, got.bus_value, got.last);
				return;
			end
			exp = pending_beats.pop_front();
			if (got.reg_select !== exp.reg_select) begin
				errors++;
				$display("%0t: reg_select expected %0b got %0b", $realtime,
					exp.reg_select, got.reg_select);
			end
			if (got.bus_value !== exp.bus_value) begin
				errors++;
				$display("%0t: bus_value expected %02h got %02h", $realtime,
					exp.bus_value, got.bus_value);
			end
			if (got.last !== exp.last) begin
				errors++;
				$display("%0t: last expected %0b got %0b", $realtime, exp.last, got.last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        strobe;
	strobe_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	strobe_scoreboard sb;
	int burst_left;

	char_lcd_command_sequencer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.strobe(strobe), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("char_lcd_command_sequencer verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) sb.check_beat(result);
	end

	// hold valid across back-to-back writes; the caller drops it
	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_BUS_MODE: sb.nibble_bus = data[0];
			REG_DISP_CTL: sb.disp_ctl = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(bit mode, logic [7:0] ctl, logic [15:0] hi, logic [15:0] lo);
		write_reg(REG_BUS_MODE, {15'($urandom), mode});
		write_reg(REG_DISP_CTL, {8'($urandom), ctl});
		write_reg(REG_EN_HIGH, hi);
		write_reg(REG_EN_LOW, lo);
		cfg_valid <= 1'b0;
	endtask

	// send one command; bursts of back-to-back commands separated by random gaps
	task automatic send_cmd(cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_command(c);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (sb.pending_beats.size() > 0) @(posedge clk);
		// an ignored op never raises busy; the last beat's hold may still keep it high
		repeat (4) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		c.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
			: 4'($urandom_range(0, 9));
		c.byte_value = 8'($urandom);
		case ($urandom_range(0, 3))
			0: c.number = $urandom_range(0, 20) - 10;
			1: c.number = $urandom_range(0, 99999);
			default: c.number = $urandom;
		endcase
		c.line = 1'($urandom);
		c.column = 6'($urandom);
		c.blank_count = 5'($urandom_range(0, 31));
		c.glyph_rows = {32'($urandom), 32'($urandom)};
		return c;
	endfunction

	function automatic cmd_t make_cmd(logic [3:0] op, logic [7:0] bv, logic [31:0] num,
			bit ln, logic [5:0] col, logic [4:0] cnt, logic [63:0] rows);
		cmd_t c;
		c.op = op;
		c.byte_value = bv;
		c.number = num;
		c.line = ln;
		c.column = col;
		c.blank_count = cnt;
		c.glyph_rows = rows;
		return c;
	endfunction

	initial begin
		cmd_t directed[$];
		sb = new();
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_cmd(OP_INIT, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_INS, 8'hFF, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_CHAR, 8'h00, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_CURSOR, 0, 0, 0, 6'd63, 0, 0));
		directed.push_back(make_cmd(OP_CURSOR, 0, 0, 1, 6'd63, 0, 0));
		directed.push_back(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_DEC, 0, 32'h0, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_DEC, 0, 32'h8000_0000, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_DEC, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_DEC, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_FOUR, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_FOUR, 0, 32'd9999, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_BIN, 8'hA5, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(OP_BLANK, 0, 0, 1, 6'd5, 5'd0, 0));
		directed.push_back(make_cmd(OP_BLANK, 0, 0, 0, 6'd63, 5'd31, 0));
		directed.push_back(make_cmd(OP_BLANK, 0, 0, 1, 6'd0, 5'd16, 0));
		directed.push_back(make_cmd(OP_GLYPH, 8'hFF, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
		directed.push_back(make_cmd(OP_GLYPH, 8'h00, 0, 0, 0, 0, 64'h0));
		directed.push_back(make_cmd(4'd10, 8'hFF, 0, 0, 0, 0, 0));
		directed.push_back(make_cmd(4'd15, 8'hFF, 0, 0, 0, 0, 0));

		set_config(1'b0, 8'h00, 16'd1, 16'd1);
		foreach (directed[i]) send_cmd(directed[i]);
		drain();
		set_config(1'b1, 8'hFF, 16'd2, 16'd1);
		foreach (directed[i]) send_cmd(directed[i]);
		drain();

		// extreme hold times, one short command each
		set_config(1'b0, 8'h0C, 16'hFFFF, 16'd1);
		send_cmd(make_cmd(OP_CHAR, 8'h41, 0, 0, 0, 0, 0));
		drain();
		set_config(1'b0, 8'h0C, 16'd1, 16'hFFFF);
		send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			set_config(1'($urandom), 8'($urandom), 16'($urandom_range(1, 4)),
				16'($urandom_range(1, 4)));
			for (int n = 0; n < 45; n++) send_cmd(random_cmd());
			drain();
		end

		$display("Ran %0d commands over both bus widths and varied hold times; %0d beats checked.",
			sb.cmds_seen, sb.beats_seen);
		if (sb.errors == 0 && sb.pending_beats.size() == 0)
			$display("char_lcd_command_sequencer verification clean");
		else
			$display("char_lcd_command_sequencer verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/clcd_pkg.sv
rtl/core/clcd_datapath.sv
rtl/core/clcd_ctrl.sv
rtl/core/char_lcd_command_sequencer.sv
tb/char_lcd_command_sequencer_test.sv
